// ===== hw/rtl/dhz_pkg.sv =====
// Shared codes for the dehaze pixel recovery block: register indexes and output modes.
// No dependencies; imported by the top level.
package dhz_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMB_RED    = 3'd0,
    REG_AMB_GREEN  = 3'd1,
    REG_AMB_BLUE   = 3'd2,
    REG_T_FLOOR    = 3'd3,
    REG_MODE       = 3'd4,
    REG_COEF_RED   = 3'd5,
    REG_COEF_GREEN = 3'd6,
    REG_COEF_BLUE  = 3'd7
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHAN  = 2'd0,
    MODE_LUMA  = 2'd1,
    MODE_DEPTH = 2'd2
  } out_mode_t;

endpackage

// ===== hw/rtl/dhz_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Self-contained; instantiated by dehaze_pixel_recovery_unit.
module dhz_div #(
  parameter int DW = 32,
  parameter int VW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [VW-1:0] out_rem
);

  // The caller guarantees in_dividend[DW-1:QW] < in_divisor, so the quotient fits QW bits.
  logic [VW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quot_r [QW];
  logic [VW-1:0] dvs_r  [QW];
  logic          vld_r  [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [VW-1:0] rem_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] quot_i;
    logic [VW-1:0] dvs_i;
    logic          vld_i;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = VW'(in_dividend[DW-1:QW]);
      assign low_i  = in_dividend[QW-1:0];
      assign quot_i = '0;
      assign dvs_i  = in_divisor;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign low_i  = low_r[k-1];
      assign quot_i = quot_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign trial   = {rem_i, low_i[QW-1]};
    assign ge      = (trial >= {1'b0, dvs_i});
    assign rem_nxt = ge ? VW'(trial - {1'b0, dvs_i}) : VW'(trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= low_i << 1;
        quot_r[k] <= (quot_i << 1) | QW'(ge);
        dvs_r[k]  <= dvs_i;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_rem   = rem_r[QW-1];

endmodule

// ===== hw/rtl/dehaze_pixel_recovery_unit.sv =====
// Top level of the dehaze pixel recovery block: haze removal for one pixel per item.
// Depends on dhz_pkg (codes) and dhz_div (pipelined divider).
//
//   port group | direction | handshake           | payload
//   in_        | input     | in_valid / in_stall | pixel_red/green/blue, transmission, mirror
//   out_       | output    | out_valid/out_stall | out_red, out_green, out_blue (signed Q2.P)
//   cfg_       | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item enters every clock unless the output stalls; the latency comes from the chain
// of bit-serial divider pipelines (channel ratio, division by the transmission, luminance
// scaling and its remainder correction), each of which retires one quotient bit per stage.
// Reset is synchronous and active low; it clears the valid bits and loads register defaults.
// A stall on the output freezes the whole pipeline, including the output register, and is
// passed back as in_stall in the same cycle, so nothing is dropped or repeated.
module dehaze_pixel_recovery_unit #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           in_pixel_red,
  input  logic [PIXEL_BITS-1:0]           in_pixel_green,
  input  logic [PIXEL_BITS-1:0]           in_pixel_blue,
  input  logic [PIXEL_BITS-1:0]           in_transmission,
  input  logic                            in_mirror,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [PIXEL_BITS+1:0]    out_red,
  output logic signed [PIXEL_BITS+1:0]    out_green,
  output logic signed [PIXEL_BITS+1:0]    out_blue,
  input  logic                            cfg_we,
  input  logic [dhz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [PIXEL_BITS-1:0]           cfg_wdata
);

  import dhz_pkg::*;

  localparam int P   = PIXEL_BITS;
  localparam int OW  = P + 2;          // output width
  localparam int YW  = P + 2;          // luminance width
  localparam int QB  = 2 * P + 2;      // quotient of a difference over the transmission
  localparam int DB  = 2 * P + 3;
  localparam int MW  = 2 * P + 4;      // magnitude of the target luminance
  localparam int DE  = 2 * P + 3;
  localparam int QE  = P + 1;
  localparam int JW  = 2 * P + 5;      // signed working width before saturation

  localparam logic [P:0] ONE_V = {1'b1, {P{1'b0}}};
  localparam logic signed [JW-1:0] OUT_MAX = JW'(2 ** (P + 1) - 1);
  localparam logic signed [JW-1:0] OUT_MIN = -OUT_MAX - JW'(1);

  localparam logic [63:0] T0_RST64 = (64'd6554 << P) >> 16;
  localparam logic [63:0] CR_RST64 = (64'd13933 << P) >> 16;
  localparam logic [63:0] CG_RST64 = (64'd46871 << P) >> 16;
  localparam logic [63:0] CB_RST64 = (64'd4732 << P) >> 16;

  function automatic logic [OW-1:0] sat_out(input logic signed [JW-1:0] v);
    logic signed [JW-1:0] s;
    s = v;
    if (v > OUT_MAX) begin
      s = OUT_MAX;
    end else if (v < OUT_MIN) begin
      s = OUT_MIN;
    end
    return s[OW-1:0];
  endfunction

  // ------------------------------------------------------------------ configuration
  logic [P-1:0]      amb_r  [3];
  logic [P-1:0]      coef_r [3];
  logic [P-1:0]      t0_r;
  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r[0]  <= {P{1'b1}};
      amb_r[1]  <= {P{1'b1}};
      amb_r[2]  <= {P{1'b1}};
      t0_r      <= T0_RST64[P-1:0];
      mode_r    <= MODE_CHAN;
      coef_r[0] <= CR_RST64[P-1:0];
      coef_r[1] <= CG_RST64[P-1:0];
      coef_r[2] <= CB_RST64[P-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMB_RED:    amb_r[0]  <= cfg_wdata;
        REG_AMB_GREEN:  amb_r[1]  <= cfg_wdata;
        REG_AMB_BLUE:   amb_r[2]  <= cfg_wdata;
        REG_T_FLOOR:    t0_r      <= cfg_wdata;
        REG_MODE:       mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_COEF_RED:   coef_r[0] <= cfg_wdata;
        REG_COEF_GREEN: coef_r[1] <= cfg_wdata;
        REG_COEF_BLUE:  coef_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero ambient or floor register acts as one LSB.
  logic [P-1:0] amb_eff [3];
  logic [P-1:0] t0_eff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      amb_eff[c] = (amb_r[c] == '0) ? P'(1) : amb_r[c];
    end
    t0_eff = (t0_r == '0) ? P'(1) : t0_r;
  end

  // Ambient luminance only changes with configuration, so it is kept in registers.
  logic [2*P-1:0] ay_prod_r [3];
  logic [YW-1:0]  ay_r;
  logic [2*P+1:0] ay_sum;

  assign ay_sum = (2*P+2)'(ay_prod_r[0]) + (2*P+2)'(ay_prod_r[1]) + (2*P+2)'(ay_prod_r[2]);

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      ay_prod_r[c] <= coef_r[c] * amb_eff[c];
    end
    ay_r <= ay_sum[2*P+1:P];
  end

  // ------------------------------------------------------------------ flow control
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ------------------------------------------------------------------ stage A: channel ratios
  // ratio = (pixel << P) / ambient, only needed below ONE; a pixel at or above its ambient
  // gives ONE directly and the divider gets a zero dividend.
  typedef struct packed {
    logic [2:0][P-1:0] px;
    logic [P-1:0]      t;
    logic              haze;
    logic [2:0]        ge;
  } sa_t;

  logic [P-1:0]   px_in  [3];
  logic [2*P-1:0] a_dvd  [3];
  logic [2:0]     a_ge;
  logic [P-1:0]   qa     [3];
  logic           a_vld;
  sa_t            sa_nxt;
  sa_t            sa_r   [P];

  assign px_in[0] = in_pixel_red;
  assign px_in[1] = in_pixel_green;
  assign px_in[2] = in_pixel_blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_ge[c]      = (px_in[c] >= amb_eff[c]);
      a_dvd[c]     = a_ge[c] ? '0 : {px_in[c], {P{1'b0}}};
      sa_nxt.px[c] = px_in[c];
    end
    sa_nxt.t    = in_transmission;
    sa_nxt.haze = in_mirror;
    sa_nxt.ge   = a_ge;
  end

  genvar g;
  for (g = 0; g < 3; g++) begin : g_div_a
    if (g == 0) begin : g_v
      dhz_div #(.DW(2 * P), .VW(P), .QW(P)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (in_valid && en),
        .in_dividend(a_dvd[g]),
        .in_divisor (amb_eff[g]),
        .out_valid  (a_vld),
        .out_quot   (qa[g]),
        .out_rem    ()
      );
    end else begin : g_nv
      dhz_div #(.DW(2 * P), .VW(P), .QW(P)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (in_valid && en),
        .in_dividend(a_dvd[g]),
        .in_divisor (amb_eff[g]),
        .out_valid  (),
        .out_quot   (qa[g]),
        .out_rem    ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[0] <= sa_nxt;
      for (int k = 1; k < P; k++) begin
        sa_r[k] <= sa_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------------ stage M1: mt, luma products
  logic [P:0]     qe [3];
  logic [P:0]     minq;
  logic [P:0]     tl1;
  logic [P:0]     mt_nxt;
  sa_t            sa_o;

  logic           m1_vld_r;
  logic [P:0]     m1_mt_r;
  logic [2*P-1:0] m1_prod_r [3];
  logic [P-1:0]   m1_px_r   [3];
  logic           m1_haze_r;

  assign sa_o = sa_r[P-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qe[c] = sa_o.ge[c] ? ONE_V : {1'b0, qa[c]};
    end
    minq = qe[0];
    if (qe[1] < minq) minq = qe[1];
    if (qe[2] < minq) minq = qe[2];
    // Lower bound plus one LSB keeps every recovered channel non-negative.
    tl1 = ONE_V - minq + (P+1)'(1);
    mt_nxt = {1'b0, sa_o.t};
    if ({1'b0, t0_eff} > mt_nxt) mt_nxt = {1'b0, t0_eff};
    if (tl1 > mt_nxt) mt_nxt = tl1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mt_r   <= mt_nxt;
      m1_haze_r <= sa_o.haze;
      for (int c = 0; c < 3; c++) begin
        m1_prod_r[c] <= coef_r[c] * sa_o.px[c];
        m1_px_r[c]   <= sa_o.px[c];
      end
    end
  end

  // ------------------------------------------------------------------ stage M2: dividends
  logic [2*P+1:0]       ysum;
  logic [YW-1:0]        y_nxt;
  logic signed [P+2:0]  dy;
  logic signed [P:0]    dc [3];
  logic [P+1:0]         mag_nxt [3];
  logic [2:0]           neg_nxt;
  logic [P:0]           depth_nxt;

  logic                 m2_vld_r;
  logic [P+1:0]         m2_mag_r [3];
  logic [2:0]           m2_neg_r;
  logic [P:0]           m2_mt_r;
  logic [P-1:0]         m2_px_r  [3];
  logic                 m2_haze_r;
  logic [YW-1:0]        m2_y_r;
  logic [P:0]           m2_depth_r;

  assign ysum  = (2*P+2)'(m1_prod_r[0]) + (2*P+2)'(m1_prod_r[1]) + (2*P+2)'(m1_prod_r[2]);
  assign y_nxt = ysum[2*P+1:P];

  always_comb begin
    dy = signed'((P+3)'(y_nxt)) - signed'((P+3)'(ay_r));
    for (int c = 0; c < 3; c++) begin
      dc[c]      = signed'({1'b0, m1_px_r[c]}) - signed'({1'b0, amb_eff[c]});
      neg_nxt[c] = dc[c][P];
      mag_nxt[c] = dc[c][P] ? (P+2)'(-dc[c]) : (P+2)'(dc[c]);
    end
    // In luminance mode lane zero divides the luminance difference instead.
    if (mode_r == MODE_LUMA) begin
      neg_nxt[0] = dy[P+2];
      mag_nxt[0] = dy[P+2] ? (P+2)'(-dy) : (P+2)'(dy);
    end
    depth_nxt = (m1_mt_r > ONE_V) ? '0 : ONE_V - m1_mt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_neg_r   <= neg_nxt;
      m2_mt_r    <= m1_mt_r;
      m2_haze_r  <= m1_haze_r;
      m2_y_r     <= y_nxt;
      m2_depth_r <= depth_nxt;
      for (int c = 0; c < 3; c++) begin
        m2_mag_r[c] <= mag_nxt[c];
        m2_px_r[c]  <= m1_px_r[c];
      end
    end
  end

  // ------------------------------------------------------------------ stage B: divide by mt
  typedef struct packed {
    logic [2:0][P-1:0] px;
    logic              haze;
    logic [YW-1:0]     y;
    logic [P:0]        depth;
    logic [2:0]        neg;
  } sb_t;

  logic [QB-1:0] qb [3];
  logic          b_vld;
  sb_t           sb_nxt;
  sb_t           sb_r [QB];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sb_nxt.px[c] = m2_px_r[c];
    end
    sb_nxt.haze  = m2_haze_r;
    sb_nxt.y     = m2_y_r;
    sb_nxt.depth = m2_depth_r;
    sb_nxt.neg   = m2_neg_r;
  end

  for (g = 0; g < 3; g++) begin : g_div_b
    if (g == 0) begin : g_v
      dhz_div #(.DW(DB), .VW(P + 1), .QW(QB)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (m2_vld_r),
        .in_dividend({1'b0, m2_mag_r[g], {P{1'b0}}}),
        .in_divisor (m2_mt_r),
        .out_valid  (b_vld),
        .out_quot   (qb[g]),
        .out_rem    ()
      );
    end else begin : g_nv
      dhz_div #(.DW(DB), .VW(P + 1), .QW(QB)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (m2_vld_r),
        .in_dividend({1'b0, m2_mag_r[g], {P{1'b0}}}),
        .in_divisor (m2_mt_r),
        .out_valid  (),
        .out_quot   (qb[g]),
        .out_rem    ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int k = 1; k < QB; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------------ stage C: recovery
  sb_t                  sb_o;
  logic signed [JW-1:0] qs [3];
  logic signed [JW-1:0] jv [3];
  logic signed [JW-1:0] yy;
  logic [OW-1:0]        res_nxt [3];
  logic                 dark;
  logic                 lum_nxt;

  logic                 c_vld_r;
  logic [OW-1:0]        c_res_r [3];
  logic                 c_lum_r;
  logic [MW-1:0]        c_m_r;
  logic                 c_yneg_r;
  logic [YW-1:0]        c_y_r;
  logic [P-1:0]         c_px_r  [3];

  assign sb_o = sb_r[QB-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qs[c] = signed'(JW'(qb[c]));
      if (sb_o.neg[c]) qs[c] = -qs[c];
      jv[c] = qs[c] + signed'(JW'(amb_eff[c]));
      if (sb_o.haze) jv[c] = signed'(JW'({sb_o.px[c], 1'b0})) - jv[c];
    end
    // Target luminance; when haze is added it is mirrored about the input luminance.
    yy = qs[0] + signed'(JW'(ay_r));
    if (sb_o.haze) yy = signed'(JW'({sb_o.y, 1'b0})) - yy;

    dark    = (sb_o.y <= YW'(1));
    lum_nxt = (mode_r == MODE_LUMA) && !dark;
    for (int c = 0; c < 3; c++) begin
      if (mode_r == MODE_DEPTH) begin
        res_nxt[c] = OW'(sb_o.depth);
      end else if (mode_r == MODE_LUMA) begin
        res_nxt[c] = OW'(sb_o.px[c]);
      end else begin
        res_nxt[c] = sat_out(jv[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lum_r  <= lum_nxt;
      c_m_r    <= yy[JW-1] ? MW'(-yy) : MW'(yy);
      c_yneg_r <= yy[JW-1];
      c_y_r    <= sb_o.y;
      for (int c = 0; c < 3; c++) begin
        c_res_r[c] <= res_nxt[c];
        c_px_r[c]  <= sb_o.px[c];
      end
    end
  end

  // ------------------------------------------------------------------ stage E: |yy| / y
  // The ratio only matters up to 2*ONE; beyond that the output saturates.
  typedef struct packed {
    logic [2:0][OW-1:0] res;
    logic               lum;
    logic               yneg;
    logic               ovf;
    logic [YW-1:0]      y;
    logic [2:0][P-1:0]  px;
  } se_t;

  logic          e_ovf;
  logic [DE-1:0] e_dvd;
  logic [QE-1:0] qe_q;
  logic [YW-1:0] re_r;
  logic          e_vld;
  se_t           se_nxt;
  se_t           se_r [QE];

  assign e_ovf = ((c_m_r >> (P + 1)) >= MW'(c_y_r));
  assign e_dvd = e_ovf ? '0 : c_m_r[DE-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      se_nxt.res[c] = c_res_r[c];
      se_nxt.px[c]  = c_px_r[c];
    end
    se_nxt.lum  = c_lum_r;
    se_nxt.yneg = c_yneg_r;
    se_nxt.ovf  = e_ovf;
    se_nxt.y    = c_y_r;
  end

  dhz_div #(.DW(DE), .VW(YW), .QW(QE)) u_div_e (
    .clk, .rst_n, .en,
    .in_valid   (c_vld_r),
    .in_dividend(e_dvd),
    .in_divisor (c_y_r),
    .out_valid  (e_vld),
    .out_quot   (qe_q),
    .out_rem    (re_r)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      se_r[0] <= se_nxt;
      for (int k = 1; k < QE; k++) begin
        se_r[k] <= se_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------------ stage F: products
  se_t            se_o;
  logic           f_vld_r;
  logic [2*P:0]   f_xq_r [3];
  logic [2*P+1:0] f_xr_r [3];
  logic [OW-1:0]  f_res_r [3];
  logic [2:0]     f_xz_r;
  logic           f_lum_r;
  logic           f_yneg_r;
  logic           f_ovf_r;
  logic [YW-1:0]  f_y_r;

  assign se_o = se_r[QE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        f_xq_r[c]  <= se_o.px[c] * qe_q;
        f_xr_r[c]  <= se_o.px[c] * re_r;
        f_res_r[c] <= se_o.res[c];
        f_xz_r[c]  <= (se_o.px[c] == '0);
      end
      f_lum_r  <= se_o.lum;
      f_yneg_r <= se_o.yneg;
      f_ovf_r  <= se_o.ovf;
      f_y_r    <= se_o.y;
    end
  end

  // ------------------------------------------------------------------ stage G: (x * r) / y
  typedef struct packed {
    logic [2:0][2*P:0]  xq;
    logic [2:0][OW-1:0] res;
    logic               lum;
    logic               yneg;
    logic               ovf;
    logic [2:0]         xz;
  } sg_t;

  logic [P-1:0] qg [3];
  logic         g_vld;
  sg_t          sg_nxt;
  sg_t          sg_r [P];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sg_nxt.xq[c]  = f_xq_r[c];
      sg_nxt.res[c] = f_res_r[c];
    end
    sg_nxt.lum  = f_lum_r;
    sg_nxt.yneg = f_yneg_r;
    sg_nxt.ovf  = f_ovf_r;
    sg_nxt.xz   = f_xz_r;
  end

  for (g = 0; g < 3; g++) begin : g_div_g
    if (g == 0) begin : g_v
      dhz_div #(.DW(2 * P + 2), .VW(YW), .QW(P)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (f_vld_r),
        .in_dividend(f_xr_r[g]),
        .in_divisor (f_y_r),
        .out_valid  (g_vld),
        .out_quot   (qg[g]),
        .out_rem    ()
      );
    end else begin : g_nv
      dhz_div #(.DW(2 * P + 2), .VW(YW), .QW(P)) u_div (
        .clk, .rst_n, .en,
        .in_valid   (f_vld_r),
        .in_dividend(f_xr_r[g]),
        .in_divisor (f_y_r),
        .out_valid  (),
        .out_quot   (qg[g]),
        .out_rem    ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r[0] <= sg_nxt;
      for (int k = 1; k < P; k++) begin
        sg_r[k] <= sg_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------------ stage H: output register
  sg_t            sg_o;
  logic [2*P+1:0] v     [3];
  logic [OW-1:0]  fin   [3];
  logic [OW-1:0]  out_r [3];

  assign sg_o = sg_r[P-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c] = (2*P+2)'(sg_o.xq[c]) + (2*P+2)'(qg[c]);
      if (!sg_o.lum) begin
        fin[c] = sg_o.res[c];
      end else if (sg_o.xz[c]) begin
        fin[c] = '0;
      end else if (sg_o.ovf || (v[c] >= (2*P+2)'(2 * ONE_V))) begin
        fin[c] = sg_o.yneg ? OUT_MIN[OW-1:0] : OUT_MAX[OW-1:0];
      end else begin
        fin[c] = sg_o.yneg ? OW'(-v[c]) : OW'(v[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        out_r[c] <= fin[c];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

endmodule
